// ===== rtl/bfdh_pkg.sv =====
`default_nettype none

package bfdh_pkg;

    localparam int HASH_W    = 64;
    localparam int DIV_CNT_W = 6;
    localparam int BC_W      = 17;
    localparam int HC_W      = 5;
    localparam int CFG_W     = 17;
    localparam int IN_DATA_W = 128;
    localparam int OUT_DATA_W = 8;

    localparam logic CFG_BIT_COUNT  = 1'b0;
    localparam logic CFG_HASH_COUNT = 1'b1;

    localparam logic [BC_W-1:0] BIT_COUNT_RST  = 17'd65536;
    localparam logic [HC_W-1:0] HASH_COUNT_RST = 5'd7;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_MEM   = 6'b001000,
        S_CHECK = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic div_step;
        logic mem_write;
        logic mem_read;
        logic check;
        logic advance;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic div_last;
        logic hash_last;
        logic k_zero;
        logic is_query;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/bfdh_ctrl.sv =====
`default_nettype none

module bfdh_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire bfdh_pkg::t_status i_status,
    output bfdh_pkg::t_cmd        o_cmd
);
    import bfdh_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.k_zero ? S_FIN : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_MEM;
                end
            end
            S_MEM: begin
                if (i_status.is_query) begin
                    o_cmd.mem_read = 1'b1;
                    n_state        = S_CHECK;
                end else begin
                    o_cmd.mem_write = 1'b1;
                    o_cmd.advance   = 1'b1;
                    n_state         = i_status.hash_last ? S_FIN : S_DIV;
                end
            end
            S_CHECK: begin
                o_cmd.check   = 1'b1;
                o_cmd.advance = 1'b1;
                n_state       = i_status.hash_last ? S_FIN : S_DIV;
            end
            S_FIN: begin
                if (!i_status.is_query) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bfdh_datapath.sv =====
`default_nettype none

module bfdh_datapath #(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_HASHES = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_addr,
    input  wire logic [bfdh_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                           i_mode,
    input  wire logic [bfdh_pkg::HASH_W-1:0]    i_first_hash,
    input  wire logic [bfdh_pkg::HASH_W-1:0]    i_second_hash,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_present,
    input  wire bfdh_pkg::t_cmd                 i_cmd,
    output bfdh_pkg::t_status                   o_status
);
    import bfdh_pkg::*;

    localparam int AW  = $clog2(MAX_BITS);
    localparam int MW  = $clog2(MAX_BITS + 1);
    localparam int RW  = MW + 1;
    localparam int CW  = (MW > BC_W) ? MW : BC_W;
    localparam int KW  = $clog2(MAX_HASHES + 1);
    localparam int KCW = (KW > HC_W) ? KW : HC_W;

    // configuration registers
    logic [BC_W-1:0] r_bit_count;
    logic [HC_W-1:0] r_hash_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count  <= BIT_COUNT_RST;
            r_hash_count <= HASH_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_BIT_COUNT:  r_bit_count  <= i_cfg_wdata[BC_W-1:0];
                CFG_HASH_COUNT: r_hash_count <= i_cfg_wdata[HC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective modulus and hash count
    logic [CW-1:0]  bc_ext;
    logic [MW-1:0]  m_eff;
    logic [KCW-1:0] hc_ext;
    logic [KW-1:0]  k_eff;

    always_comb begin
        bc_ext = CW'(r_bit_count);
        if (bc_ext == '0) begin
            m_eff = MW'(1);
        end else if (bc_ext > CW'(MAX_BITS)) begin
            m_eff = MW'(MAX_BITS);
        end else begin
            m_eff = MW'(bc_ext);
        end
        hc_ext = KCW'(r_hash_count);
        if (hc_ext > KCW'(MAX_HASHES)) begin
            k_eff = KW'(MAX_HASHES);
        end else begin
            k_eff = KW'(hc_ext);
        end
    end

    // per-item state
    logic              r_mode;
    logic [HASH_W-1:0] r_comb;
    logic [HASH_W-1:0] r_step;
    logic [KW-1:0]     r_hcnt;
    logic              r_all;
    logic              r_rd_bit;
    logic [HASH_W-1:0] n_comb;

    assign n_comb = r_comb + r_step;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_comb <= i_first_hash;
            r_step <= i_second_hash;
            r_hcnt <= '0;
            r_all  <= 1'b1;
        end else begin
            if (i_cmd.advance) begin
                r_comb <= n_comb;
                r_hcnt <= KW'(r_hcnt + KW'(1));
            end
            if (i_cmd.check) begin
                r_all <= r_all & r_rd_bit;
            end
        end
    end

    // restoring remainder, one dividend bit per cycle
    logic [HASH_W-1:0]    r_dividend;
    logic [MW-1:0]        r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [RW-1:0]        rem_trial;
    logic [RW-1:0]        m_ext;

    assign rem_trial = {r_rem, r_dividend[HASH_W-1]};
    assign m_ext     = {1'b0, m_eff};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dividend <= i_first_hash;
            r_rem      <= '0;
            r_div_cnt  <= '0;
        end else if (i_cmd.advance) begin
            r_dividend <= n_comb;
            r_rem      <= '0;
            r_div_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[HASH_W-2:0], 1'b0};
            r_div_cnt  <= DIV_CNT_W'(r_div_cnt + DIV_CNT_W'(1));
            if (rem_trial >= m_ext) begin
                r_rem <= MW'(rem_trial - m_ext);
            end else begin
                r_rem <= MW'(rem_trial);
            end
        end
    end

    // bit store with clearing pass after reset
    logic          r_mem [MAX_BITS];
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] bit_idx;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    assign bit_idx = r_rem[AW-1:0];
    assign wr_en   = i_cmd.clear_step | i_cmd.mem_write;
    assign wr_addr = i_cmd.clear_step ? r_clr_addr : bit_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= AW'(r_clr_addr + AW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= ~i_cmd.clear_step;
        end
        if (i_cmd.mem_read) begin
            r_rd_bit <= r_mem[bit_idx];
        end
    end

    // output register
    logic r_out_valid;
    logic r_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_present <= r_all;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_present   = r_present;

    always_comb begin
        o_status.clear_last = (r_clr_addr == AW'(MAX_BITS - 1));
        o_status.div_last   = (r_div_cnt == DIV_CNT_W'(HASH_W - 1));
        o_status.hash_last  = (KW'(r_hcnt + KW'(1)) == k_eff);
        o_status.k_zero     = (k_eff == '0);
        o_status.is_query   = (r_mode == MODE_QUERY);
        o_status.out_free   = ~r_out_valid | i_out_ready;
    end

endmodule

`default_nettype wire

// ===== rtl/bloom_filter_double_hash_core.sv =====
`default_nettype none

// bloom filter over an internal bit store, k indices per key by double hashing
// input channel s_axis: tdata carries the two 64-bit base hashes, tuser the mode
// (0 insert, 1 query); one request is taken at a time, tready is high only when idle
// output channel m_axis: one result per query, tdata bit 0 is present; inserts
// give nothing
// each index is first + i*second reduced modulo the bit count by a restoring
// remainder unit that takes one dividend bit per cycle, then a store step
// (insert) or a read and a check step (query)
// an insert frees the input after its last store step; a query loads its result
// after its last check step and frees the input in the next cycle
// the output register lets the block take the next request while a result waits;
// a second query result stalls in the final step until the receiver takes the first
// after reset the bit store is cleared one bit per cycle, with
// tready low; configuration writes are taken at any time, also during the clear
// configuration is register 0 bit_count and register 1 hash_count
module bloom_filter_double_hash_core #(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_HASHES = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_addr,
    input  wire logic [bfdh_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // first_hash [63:0], second_hash [127:64]
    input  wire logic [bfdh_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // mode [0]
    input  wire logic                               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // present [0], zero fill [7:1]
    output logic [bfdh_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);
    import bfdh_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    present;

    bfdh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bfdh_datapath #(
        .MAX_BITS   (MAX_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_mode        (s_axis_tuser),
        .i_first_hash  (s_axis_tdata[HASH_W-1:0]),
        .i_second_hash (s_axis_tdata[2*HASH_W-1:HASH_W]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_present     (present),
        .i_cmd         (cmd),
        .o_status      (status)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-1){1'b0}}, present};

`ifndef SYNTH
    // a request is taken only once; the next cycle the block is busy
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted on two consecutive cycles");

    // a new result never overwrites one the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending result");

    // a query never writes the bit store
    a_query_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mem_write |-> !status.is_query)
        else $error("bit store written during a query");

    // the clearing pass keeps the input closed
    a_clear_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear_step |-> !s_axis_tready)
        else $error("input open during clearing pass");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_bloom_filter_double_hash_core.sv =====
module tb_bloom_filter_double_hash_core;
    import bfdh_pkg::*;

    localparam int STORE_BITS = 65536;
    localparam int PROBE_LIMIT = 16;
    localparam int SETTLE_CYCLES = 1200;
    localparam int HOLD_CYCLES = 4000;
    // slowest run: ~600 requests at k = 16 with stalls, the clear pass, the pauses
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int POOL_DEPTH = 64;
    localparam int MAX_REPORTS = 40;

    typedef enum {CHK_OK, CHK_EXTRA, CHK_WRONG} check_e;
    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;

    class bloom_shadow;
        bit marked[STORE_BITS];
        logic [BC_W-1:0] modulus_reg;
        logic [HC_W-1:0] probe_reg;
        logic present_q[$];

        function new();
            modulus_reg = BIT_COUNT_RST;
            probe_reg = HASH_COUNT_RST;
        endfunction

        function void write_register(input logic addr, input logic [CFG_W-1:0] value);
            if (addr == CFG_BIT_COUNT)
                modulus_reg = value[BC_W-1:0];
            else
                probe_reg = value[HC_W-1:0];
        endfunction

        // walk the k derived indices, set them or test them
        function void note_request(input logic mode, input logic [63:0] first,
                                   input logic [63:0] second);
            logic [63:0] modulus;
            logic [63:0] acc;
            logic [63:0] idx;
            int probes;
            int i;
            logic all_set;
            modulus = (modulus_reg == 0) ? 64'd1 :
                      (modulus_reg > STORE_BITS) ? 64'(STORE_BITS) : 64'(modulus_reg);
            probes = (probe_reg > PROBE_LIMIT) ? PROBE_LIMIT : int'(probe_reg);
            acc = first;
            all_set = 1'b1;
            for (i = 0; i < probes; i++) begin
                idx = acc % modulus;
                if (mode == MODE_INSERT)
                    marked[idx] = 1'b1;
                else if (!marked[idx])
                    all_set = 1'b0;
                acc = acc + second;
            end
            if (mode == MODE_QUERY)
                present_q = {present_q, all_set};
        endfunction

        function check_e check_present(input logic got, output logic want);
            if (present_q.size() == 0) begin
                want = 1'bx;
                return CHK_EXTRA;
            end
            want = present_q.pop_front();
            return (got === want) ? CHK_OK : CHK_WRONG;
        endfunction

        function int pending();
            return present_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_addr;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic s_axis_tvalid;
    wire logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    wire logic m_axis_tvalid;
    logic m_axis_tready;
    wire logic [OUT_DATA_W-1:0] m_axis_tdata;

    bloom_shadow shadow;
    logic [127:0] key_pool[$];
    int tx_pct;
    int rx_pct;
    logic long_hold;
    int cycles = 0;
    int errors = 0;
    int inserts = 0;
    int queries = 0;
    int hits = 0;
    int settings = 0;
    check_e verdict;
    logic want;

    bloom_filter_double_hash_core #(
        .MAX_BITS(STORE_BITS),
        .MAX_HASHES(PROBE_LIMIT)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            verdict = shadow.check_present(m_axis_tdata[0], want);
            if (m_axis_tdata[0] === 1'b1)
                hits++;
            if (verdict == CHK_EXTRA)
                report_mismatch("present result with no query waiting");
            else if (verdict == CHK_WRONG)
                report_mismatch($sformatf("present %b, expected %b", m_axis_tdata[0], want));
        end
    end

    // receiver: random stalls, or one long hold-off when asked
    initial begin : receiver
        int held;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge i_clk);
                long_hold <= 1'b0;
            end
            m_axis_tready <= (rx_pct == 0) || ($urandom_range(99) >= rx_pct);
        end
    end

    task automatic set_idle(input idle_e how);
        tx_pct = (how == IDLE_SENDER) ? 77 : (how == IDLE_BOTH) ? 29 : 0;
        rx_pct = (how == IDLE_RECEIVER) ? 77 : (how == IDLE_BOTH) ? 29 : 0;
    endtask

    task automatic send_request(input logic mode, input logic [63:0] first,
                                input logic [63:0] second);
        while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {second, first};
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1)
            @(posedge i_clk);
        shadow.note_request(mode, first, second);
        if (mode == MODE_QUERY)
            queries++;
        else
            inserts++;
    endtask

    // wait for every result, then let a trailing insert finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [BC_W-1:0] bits, input logic [HC_W-1:0] probes);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_BIT_COUNT;
        i_cfg_wdata <= CFG_W'(bits);
        @(posedge i_clk);
        shadow.write_register(CFG_BIT_COUNT, CFG_W'(bits));
        i_cfg_addr <= CFG_HASH_COUNT;
        i_cfg_wdata <= CFG_W'(probes);
        @(posedge i_clk);
        shadow.write_register(CFG_HASH_COUNT, CFG_W'(probes));
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    // queries of remembered keys, inserts of fresh keys that are remembered, and queries of fresh keys
    task automatic random_burst(input int count);
        int n;
        int pick;
        logic [127:0] key;
        logic [63:0] first;
        logic [63:0] second;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (key_pool.size() != 0 && pick < 45) begin
                key = key_pool[$urandom_range(key_pool.size() - 1)];
                send_request(MODE_QUERY, key[63:0], key[127:64]);
            end else begin
                first = {$urandom, $urandom};
                second = ($urandom_range(9) == 0) ? 64'd0 :
                         ($urandom_range(9) == 0) ? '1 : {$urandom, $urandom};
                if (pick < 75) begin
                    send_request(MODE_INSERT, first, second);
                    key = {second, first};
                    key_pool = {key_pool, key};
                    if (key_pool.size() > POOL_DEPTH)
                        void'(key_pool.pop_front());
                end else begin
                    send_request(MODE_QUERY, first, second);
                end
            end
        end
    endtask

    task automatic run_phase(input logic [BC_W-1:0] bits, input logic [HC_W-1:0] probes,
                             input idle_e how, input int count);
        set_config(bits, probes);
        set_idle(how);
        random_burst(count);
    endtask

    task automatic directed_items();
        // reset settings, empty store
        send_request(MODE_QUERY, 64'd0, 64'd0);
        send_request(MODE_INSERT, 64'd0, 64'd0);
        send_request(MODE_QUERY, 64'd0, 64'd0);
        send_request(MODE_INSERT, '1, '1);
        send_request(MODE_QUERY, '1, '1);
        send_request(MODE_QUERY, '1, 64'd1);
        send_request(MODE_QUERY, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
        send_request(MODE_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(MODE_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        // single bit in use, single probe
        set_config(17'd1, 5'd1);
        send_request(MODE_QUERY, 64'h1234_5678_9ABC_DEF0, 64'hFEDC_BA98_7654_3210);
        // zero bit count acts as one, oversized hash count clamps
        set_config(17'd0, 5'd31);
        send_request(MODE_QUERY, 64'd123, 64'd456);
        send_request(MODE_INSERT, 64'd123, 64'd456);
        send_request(MODE_QUERY, 64'd123, 64'd456);
        // oversized bit count clamps, zero hash count touches nothing
        set_config(17'h1FFFF, 5'd0);
        send_request(MODE_QUERY, '1, 64'd0);
        send_request(MODE_INSERT, 64'd77, 64'd3);
        // shrink, insert, grow, shrink again: upper bits keep their values
        set_config(17'd8, 5'd3);
        send_request(MODE_INSERT, 64'h10, 64'h3);
        send_request(MODE_QUERY, 64'h5, 64'h1);
        set_config(17'd65536, 5'd3);
        send_request(MODE_QUERY, 64'h10, 64'h3);
        send_request(MODE_QUERY, 64'h3, 64'h1);
        set_config(17'd8, 5'd3);
        send_request(MODE_QUERY, 64'h10, 64'h3);
    endtask

    initial begin
        int n;
        shadow = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        long_hold = 1'b0;
        tx_pct = 0;
        rx_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_items();
        run_phase(17'd1024, 5'd3, IDLE_NONE, 80);
        run_phase(17'($urandom_range(65536, 1)), 5'd5, IDLE_SENDER, 80);
        run_phase(17'd200, 5'd2, IDLE_RECEIVER, 80);
        run_phase(17'd65536, 5'd16, IDLE_BOTH, 30);
        run_phase(17'h1FFFF, 5'd31, IDLE_NONE, 20);

        // output held off long enough for the block to back up into its input
        set_config(17'd64, 5'd1);
        set_idle(IDLE_NONE);
        long_hold <= 1'b1;
        for (n = 0; n < 25; n++)
            send_request(MODE_QUERY, {$urandom, $urandom}, {$urandom, $urandom});
        // sender pauses until the output side has caught up
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending() != 0)
            @(posedge i_clk);
        random_burst(35);

        run_phase(17'($urandom_range(4096, 0)), 5'd0, IDLE_SENDER, 30);
        run_phase(17'($urandom_range(131071, 0)), 5'($urandom_range(31, 0)), IDLE_BOTH, 80);
        run_phase(17'($urandom_range(512, 2)), 5'($urandom_range(8, 1)), IDLE_RECEIVER, 60);
        settle();

        $display("ran %0d inserts and %0d queries (%0d answered present) over %0d settings",
                 inserts, queries, hits, settings);
        $display("incl. zero and oversized bit and hash counts, shrunk store, long output hold-off");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
